// ----- hdl/imu_fp_pkg.sv -----
// constants for the imu frame parser: header and type bytes, result kinds,
// register indexes and register reset values
// no dependencies
package imu_fp_pkg;

    localparam int FRAME_LEN_DEF = 11;
    // bytes 0..7 hold the header, the type and the three samples
    localparam int FRAME_TAPS    = 8;

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] TYPE_ACCEL  = 8'h51;
    localparam logic [7:0] TYPE_GYRO   = 8'h52;
    localparam logic [7:0] TYPE_ANGLE  = 8'h53;

    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_GYRO  = 2'd1;
    localparam logic [1:0] KIND_ANGLE = 2'd2;

    localparam logic [1:0] CFG_ACCEL_FS = 2'd0;
    localparam logic [1:0] CFG_GYRO_FS  = 2'd1;
    localparam logic [1:0] CFG_ANGLE_FS = 2'd2;

    localparam logic [23:0] ACCEL_FS_RESET = 24'd10276045;
    localparam logic [23:0] GYRO_FS_RESET  = 24'd2287634;
    localparam logic [23:0] ANGLE_FS_RESET = 24'd11796480;

    typedef logic [7:0] t_byte;

endpackage

// ----- hdl/imu_frame_parser_unit.sv -----
// imu frame parser top level: byte input register, frame collection with
// running checksum, sample scaling and result register
// depends on imu_fp_pkg
//
// usage:
//   input channel: one received byte per word on i_rx_byte, taken when
//   i_in_valid is high and o_in_stall is low. bytes are dropped until the
//   header arrives, then FRAME_LEN bytes form one frame.
//   output channel: one word per good frame of a known type, offered with
//   o_out_valid and held while i_out_stall is high.
//   config channel: i_cfg_index / i_cfg_data written when i_cfg_valid and
//   o_cfg_ready are high; ready is always high, unknown indexes are ignored.
// throughput: one byte per cycle unless a held result stalls the input; the
//   checksum compare and 16x24 scaling multiply on the last byte take one pass.
// result path: the last byte of a frame is taken into the input register,
//   and the result register loads when that byte is processed from there
//   (input register, then result register).
// stalls: while the receiver stalls, a held result blocks only the byte
//   that sits in the input register; the input stalls in turn.
// reset: synchronous active low, clears the byte count, the running sum,
//   both valid flags and loads the default full scales.
module imu_frame_parser_unit #(
    parameter int FRAME_LEN = imu_fp_pkg::FRAME_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    // result output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_frame_kind,
    output logic signed [15:0] o_raw_x,
    output logic signed [15:0] o_raw_y,
    output logic signed [15:0] o_raw_z,
    output logic signed [24:0] o_scaled_x,
    output logic signed [24:0] o_scaled_y,
    output logic signed [24:0] o_scaled_z,
    // register writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    localparam int CW = $clog2(FRAME_LEN);
    localparam logic [CW-1:0] LAST_CNT = CW'(FRAME_LEN - 1);
    localparam int TAPS = imu_fp_pkg::FRAME_TAPS;

    // configuration
    logic [23:0] r_accel_fs, r_gyro_fs, r_angle_fs;

    // input register
    logic               r_in_valid;
    imu_fp_pkg::t_byte  r_in_byte;

    // frame collection
    logic [CW-1:0]      r_count, n_count;
    logic [7:0]         r_sum, n_sum;
    imu_fp_pkg::t_byte  r_store [TAPS];

    // result register
    logic               r_out_valid;
    logic [1:0]         r_out_kind;
    logic signed [15:0] r_raw [3];
    logic signed [24:0] r_scaled [3];

    logic               out_free, proc, take, last, hit;
    logic               store_we;
    logic [1:0]         kind;
    logic [23:0]        fs;
    imu_fp_pkg::t_byte  cur [TAPS];
    logic signed [15:0] raw [3];
    logic signed [40:0] prod [3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_fs <= imu_fp_pkg::ACCEL_FS_RESET;
            r_gyro_fs  <= imu_fp_pkg::GYRO_FS_RESET;
            r_angle_fs <= imu_fp_pkg::ANGLE_FS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                imu_fp_pkg::CFG_ACCEL_FS: r_accel_fs <= i_cfg_data;
                imu_fp_pkg::CFG_GYRO_FS:  r_gyro_fs  <= i_cfg_data;
                imu_fp_pkg::CFG_ANGLE_FS: r_angle_fs <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the byte in the input register moves on unless a held result is stuck
    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_comb begin
        take = (r_count != '0) || (r_in_byte == imu_fp_pkg::HEADER_BYTE);
        last = take && (r_count == LAST_CNT);
        n_count = r_count;
        n_sum   = r_sum;
        if (take) begin
            if (last) begin
                n_count = '0;
                n_sum   = '0;
            end else begin
                n_count = r_count + CW'(1);
                n_sum   = r_sum + r_in_byte;
            end
        end
        store_we = take && (int'(r_count) < TAPS);

        // the last byte of a short frame can still be a sample byte
        for (int j = 0; j < TAPS; j++) begin
            cur[j] = (j == FRAME_LEN - 1) ? r_in_byte : r_store[j];
        end

        kind = imu_fp_pkg::KIND_ACCEL;
        fs   = r_accel_fs;
        hit  = 1'b1;
        unique case (cur[1])
            imu_fp_pkg::TYPE_ACCEL: begin
                kind = imu_fp_pkg::KIND_ACCEL;
                fs   = r_accel_fs;
            end
            imu_fp_pkg::TYPE_GYRO: begin
                kind = imu_fp_pkg::KIND_GYRO;
                fs   = r_gyro_fs;
            end
            imu_fp_pkg::TYPE_ANGLE: begin
                kind = imu_fp_pkg::KIND_ANGLE;
                fs   = r_angle_fs;
            end
            default: begin
                hit = 1'b0;
            end
        endcase
        // checksum covers every byte before the last one
        hit = hit && last && (r_sum == r_in_byte);

        for (int k = 0; k < 3; k++) begin
            raw[k]  = $signed({cur[2*k+3], cur[2*k+2]});
            prod[k] = 41'(raw[k]) * $signed({17'd0, fs});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else if (proc) begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && store_we) begin
            r_store[r_count[2:0]] <= r_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && hit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && hit) begin
            r_out_kind <= kind;
            for (int k = 0; k < 3; k++) begin
                r_raw[k]    <= raw[k];
                // arithmetic shift by 15, the result fits 25 bits
                r_scaled[k] <= prod[k][39:15];
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_kind = r_out_kind;
    assign o_raw_x      = r_raw[0];
    assign o_raw_y      = r_raw[1];
    assign o_raw_z      = r_raw[2];
    assign o_scaled_x   = r_scaled[0];
    assign o_scaled_y   = r_scaled[1];
    assign o_scaled_z   = r_scaled[2];

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) < FRAME_LEN)
        else $error("byte count beyond frame length");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(proc))
        else $error("result without a processed byte");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_kind <= imu_fp_pkg::KIND_ANGLE))
        else $error("result kind out of range");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input byte lost");

endmodule

// ----- bench/imu_frame_parser_unit_tb.sv -----
// self-checking bench for imu_frame_parser_unit: streams header-led frames, noise and broken
// frames through the byte port and checks every result against a frame predictor
// depends on imu_fp_pkg and hdl/imu_frame_parser_unit.sv
module imu_frame_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LEN  = imu_fp_pkg::FRAME_LEN_DEF;
    localparam int DRAIN_CYC  = 8;
    localparam int STALL_MAX  = 4000;
    localparam int PHASE_LEN  = 420;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
        logic signed [24:0] sc_x;
        logic signed [24:0] sc_y;
        logic signed [24:0] sc_z;
    } t_imu_sample;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = imu_fp_pkg::CFG_ACCEL_FS;
    logic [23:0] cfg_data = 24'd0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic [1:0]         o_frame_kind;
    logic signed [15:0] o_raw_x, o_raw_y, o_raw_z;
    logic signed [24:0] o_scaled_x, o_scaled_y, o_scaled_z;
    logic               o_cfg_ready;

    imu_frame_parser_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_frame_kind(o_frame_kind),
        .o_raw_x     (o_raw_x),
        .o_raw_y     (o_raw_y),
        .o_raw_z     (o_raw_z),
        .o_scaled_x  (o_scaled_x),
        .o_scaled_y  (o_scaled_y),
        .o_scaled_z  (o_scaled_z),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // predictor state
    logic [23:0]       fs_accel = imu_fp_pkg::ACCEL_FS_RESET;
    logic [23:0]       fs_gyro  = imu_fp_pkg::GYRO_FS_RESET;
    logic [23:0]       fs_angle = imu_fp_pkg::ANGLE_FS_RESET;
    int                frame_pos = 0;
    imu_fp_pkg::t_byte frame_buf [FRAME_LEN];

    imu_fp_pkg::t_byte rx_q[$];
    t_imu_sample       sample_q[$];

    bit idle_on = 1'b1;
    bit in_hold = 1'b0;
    int in_gap = 0;
    int stall_gap = 0;
    int quiet_cycles = 0;
    int errors = 0;
    int n_bytes = 0;
    int n_sent = 0;
    int n_results = 0;
    int n_writes = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [24:0] scale_raw(input logic signed [15:0] raw,
                                                     input logic [23:0] fs);
        longint prod;
        prod = longint'(raw) * longint'({40'd0, fs});
        prod = prod >>> 15;
        return prod[24:0];
    endfunction

    task automatic note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORT) $display("%s", msg);
    endtask

    // frame collection and checksum, one accepted byte at a time
    task automatic predict_byte(input imu_fp_pkg::t_byte b);
        imu_fp_pkg::t_byte sum;
        logic [23:0]       fs;
        t_imu_sample       s;
        if (frame_pos == 0 && b != imu_fp_pkg::HEADER_BYTE) return;
        frame_buf[frame_pos] = b;
        frame_pos++;
        if (frame_pos < FRAME_LEN) return;
        frame_pos = 0;
        sum = 8'h00;
        for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + frame_buf[i];
        if (sum != frame_buf[FRAME_LEN-1]) return;
        case (frame_buf[1])
            imu_fp_pkg::TYPE_ACCEL: begin s.kind = imu_fp_pkg::KIND_ACCEL; fs = fs_accel; end
            imu_fp_pkg::TYPE_GYRO:  begin s.kind = imu_fp_pkg::KIND_GYRO;  fs = fs_gyro;  end
            imu_fp_pkg::TYPE_ANGLE: begin s.kind = imu_fp_pkg::KIND_ANGLE; fs = fs_angle; end
            default: return;
        endcase
        s.raw_x = {frame_buf[3], frame_buf[2]};
        s.raw_y = {frame_buf[5], frame_buf[4]};
        s.raw_z = {frame_buf[7], frame_buf[6]};
        s.sc_x  = scale_raw(s.raw_x, fs);
        s.sc_y  = scale_raw(s.raw_y, fs);
        s.sc_z  = scale_raw(s.raw_z, fs);
        sample_q.push_back(s);
    endtask

    // byte driver
    always @(negedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && n_bytes != n_sent) begin
                // word still pending, hold it
            end else if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap--;
            end else if (rx_q.size() > 0 && !in_hold) begin
                in_valid <= 1'b1;
                rx_byte  <= rx_q[0];
                n_sent++;
                if (idle_on && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 5);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result stall driver
    always @(negedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (stall_gap > 0) begin
            out_stall <= 1'b1;
            stall_gap--;
        end else begin
            out_stall <= 1'b0;
            if (idle_on && $urandom_range(0, 7) == 0) stall_gap = $urandom_range(1, 5);
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin
        t_imu_sample got, want;
        bit          busy;
        if (rst_n) begin
            busy = 1'b0;
            if (in_valid && !o_in_stall) begin
                predict_byte(rx_byte);
                void'(rx_q.pop_front());
                n_bytes++;
                busy = 1'b1;
            end
            if (o_out_valid && !out_stall) begin
                got = '{o_frame_kind, o_raw_x, o_raw_y, o_raw_z,
                        o_scaled_x, o_scaled_y, o_scaled_z};
                busy = 1'b1;
                n_results++;
                if (sample_q.size() == 0) begin
                    note_error($sformatf("unexpected result kind %0d raw %0d %0d %0d",
                                         got.kind, got.raw_x, got.raw_y, got.raw_z));
                end else begin
                    want = sample_q.pop_front();
                    if (got.kind !== want.kind || got.raw_x !== want.raw_x ||
                        got.raw_y !== want.raw_y || got.raw_z !== want.raw_z ||
                        got.sc_x !== want.sc_x || got.sc_y !== want.sc_y ||
                        got.sc_z !== want.sc_z) begin
                        note_error($sformatf(
                            "mismatch: exp kind %0d raw %0d %0d %0d scaled %0d %0d %0d",
                            want.kind, want.raw_x, want.raw_y, want.raw_z,
                            want.sc_x, want.sc_y, want.sc_z));
                        if (errors <= MAX_REPORT)
                            $display("          got kind %0d raw %0d %0d %0d scaled %0d %0d %0d",
                                     got.kind, got.raw_x, got.raw_y, got.raw_z,
                                     got.sc_x, got.sc_y, got.sc_z);
                    end
                end
            end
            if (cfg_valid && o_cfg_ready) busy = 1'b1;
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_MAX) begin
                $display("timeout: no word moved for %0d cycles", STALL_MAX);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        while (!o_cfg_ready) @(negedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        case (idx)
            imu_fp_pkg::CFG_ACCEL_FS: fs_accel = data;
            imu_fp_pkg::CFG_GYRO_FS:  fs_gyro  = data;
            imu_fp_pkg::CFG_ANGLE_FS: fs_angle = data;
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic write_all(input logic [23:0] a, input logic [23:0] g, input logic [23:0] e);
        write_reg(imu_fp_pkg::CFG_ACCEL_FS, a);
        write_reg(imu_fp_pkg::CFG_GYRO_FS, g);
        write_reg(imu_fp_pkg::CFG_ANGLE_FS, e);
    endtask

    task automatic wait_drained;
        while (rx_q.size() != 0 || sample_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic queue_frame(input imu_fp_pkg::t_byte type_byte, input logic [15:0] x,
                               input logic [15:0] y, input logic [15:0] z, input bit bad_sum);
        imu_fp_pkg::t_byte f [FRAME_LEN];
        imu_fp_pkg::t_byte sum;
        f[0] = imu_fp_pkg::HEADER_BYTE;
        f[1] = type_byte;
        {f[3], f[2]} = x;
        {f[5], f[4]} = y;
        {f[7], f[6]} = z;
        for (int i = 8; i < FRAME_LEN - 1; i++) f[i] = $urandom_range(0, 255);
        sum = 8'h00;
        for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + f[i];
        f[FRAME_LEN-1] = bad_sum ? sum ^ imu_fp_pkg::t_byte'($urandom_range(1, 255)) : sum;
        for (int i = 0; i < FRAME_LEN; i++) rx_q.push_back(f[i]);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic imu_fp_pkg::t_byte pick_type();
        int r;
        r = $urandom_range(0, 19);
        if (r < 6) return imu_fp_pkg::TYPE_ACCEL;
        if (r < 12) return imu_fp_pkg::TYPE_GYRO;
        if (r < 18) return imu_fp_pkg::TYPE_ANGLE;
        return imu_fp_pkg::t_byte'($urandom_range(0, 255));
    endfunction

    // mostly well-formed frames, with some noise, bad sums and cut-off frames
    task automatic queue_phase(input int n);
        int framed;
        int k;
        framed = 0;
        while (framed < n) begin
            k = $urandom_range(0, 19);
            if (k == 0) begin
                repeat ($urandom_range(1, 4))
                    rx_q.push_back(imu_fp_pkg::t_byte'($urandom_range(0, 255)));
            end else if (k == 1) begin
                rx_q.push_back(imu_fp_pkg::HEADER_BYTE);
                repeat ($urandom_range(1, 9))
                    rx_q.push_back(imu_fp_pkg::t_byte'($urandom_range(0, 255)));
            end else begin
                queue_frame(pick_type(), pick_sample(), pick_sample(), pick_sample(),
                            $urandom_range(0, 9) == 0);
                framed += FRAME_LEN;
            end
        end
        // eleven non-header bytes always bring the parser back to idle
        repeat (FRAME_LEN) rx_q.push_back(8'h00);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        rst_n <= 1'b1;

        // directed: byte extremes as noise, each kind, header byte inside a frame
        rx_q.push_back(8'h00);
        rx_q.push_back(8'hFF);
        queue_frame(imu_fp_pkg::TYPE_ACCEL, 16'h8000, 16'h0055, 16'h7FFF, 1'b0);
        queue_frame(imu_fp_pkg::TYPE_GYRO, 16'hFFFF, 16'h0000, 16'h8001, 1'b0);
        queue_frame(imu_fp_pkg::TYPE_ANGLE, 16'h7FFF, 16'h8000, 16'h5555, 1'b0);
        wait_drained();

        queue_phase(PHASE_LEN);
        wait_drained();

        // full-scale maximum, plus a write to the unused index
        write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        write_reg(2'd3, 24'($urandom));
        queue_phase(PHASE_LEN);
        while (rx_q.size() > PHASE_LEN / 2) @(posedge i_clk);
        in_hold = 1'b1;
        while (sample_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        in_hold = 1'b0;
        wait_drained();

        write_all(24'd0, 24'd0, 24'd0);
        queue_phase(PHASE_LEN);
        wait_drained();

        // random scales, no idling on either side
        write_all(24'($urandom), 24'($urandom), 24'($urandom));
        write_reg(2'd3, 24'($urandom));
        idle_on = 1'b0;
        queue_phase(PHASE_LEN);
        wait_drained();

        if (sample_q.size() != 0) note_error($sformatf("%0d results never arrived",
                                                       sample_q.size()));
        $display("run covered %0d bytes, %0d results checked, %0d register writes",
                 n_bytes, n_results, n_writes);
        $display("scales ran from zero to full range; %0d mismatches", errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- imu_frame_parser_unit.f -----
hdl/imu_fp_pkg.sv
hdl/imu_frame_parser_unit.sv
bench/imu_frame_parser_unit_tb.sv
